### hdl/scd_pkg.sv
// scd_pkg: shared constants and types for the stereo crossfeed delay block
// no dependencies; compile first
package scd_pkg;

  localparam int unsigned DELAY_W    = 7;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP  = 2'd3;

  localparam logic [DELAY_W-1:0] DELAY_RST = '0;
  localparam logic [GAIN_W-1:0]  DRY_RST   = 16'd32768;
  localparam logic [GAIN_W-1:0]  WET_RST   = '0;

  // half an lsb of the q15 result
  localparam int unsigned ROUND_HALF = 16384;
  localparam int unsigned FRAC_BITS  = 15;

  // taps per group in the first level of the tap select
  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned GROUP_W    = 4;

  typedef struct packed {
    logic load_prod;
    logic load_out;
  } scd_mix_ctrl_t;

endpackage

### hdl/scd_stream_if.sv
// scd_in_if / scd_out_if: valid-ready channels for sample pairs
// depends on nothing; a beat moves when valid and ready are both high
interface scd_in_if #(
  parameter int unsigned SB = 16
) ();
  logic          valid;
  logic          ready;
  logic signed [SB-1:0] left_in;
  logic signed [SB-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scd_out_if #(
  parameter int unsigned SB = 16
) ();
  logic          valid;
  logic          ready;
  logic signed [SB-1:0] left_out;
  logic signed [SB-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### hdl/scd_cell.sv
// scd_cell: one history cell holding a stereo pair, passed on to its neighbor
// no package dependency
module scd_cell #(
  parameter int unsigned SB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic signed [SB-1:0] left_i,
  input  logic signed [SB-1:0] right_i,
  output logic signed [SB-1:0] left_o,
  output logic signed [SB-1:0] right_o
);

  logic signed [SB-1:0] left_q, left_d;
  logic signed [SB-1:0] right_q, right_d;

  always_comb begin
    left_d  = shift_i ? left_i  : left_q;
    right_d = shift_i ? right_i : right_q;
  end

  // history starts out silent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

### hdl/scd_mix.sv
// scd_mix: dry/wet products, q15 rounding and saturation for one channel
// depends on scd_pkg
module scd_mix #(
  parameter int unsigned SB = 16
) (
  input  logic                        clk_i,
  input  scd_pkg::scd_mix_ctrl_t      ctrl_i,
  input  logic signed [SB-1:0]        near_i,
  input  logic signed [SB-1:0]        far_i,
  input  logic [scd_pkg::GAIN_W-1:0]  dry_i,
  input  logic [scd_pkg::GAIN_W-1:0]  wet_i,
  output logic signed [SB-1:0]        out_o
);
  import scd_pkg::*;

  localparam int unsigned PW = SB + GAIN_W + 1;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned QW = AW - FRAC_BITS;

  logic signed [PW-1:0] dry_prod_q, dry_prod_d;
  logic signed [PW-1:0] wet_prod_q, wet_prod_d;
  logic signed [AW-1:0] acc;
  logic signed [QW-1:0] quo;
  logic signed [SB-1:0] sat;
  logic signed [SB-1:0] out_q, out_d;

  always_comb begin
    dry_prod_d = ctrl_i.load_prod
               ? PW'(near_i * $signed({1'b0, dry_i})) : dry_prod_q;
    wet_prod_d = ctrl_i.load_prod
               ? PW'(far_i * $signed({1'b0, wet_i})) : wet_prod_q;
  end

  always_comb begin
    acc = AW'(dry_prod_q) + AW'(wet_prod_q) + AW'(ROUND_HALF);
    // arithmetic shift gives floor, which is round half up after the offset
    quo = QW'(acc >>> FRAC_BITS);
    if (quo[QW-1:SB-1] == '0 || quo[QW-1:SB-1] == '1) begin
      sat = quo[SB-1:0];
    end else if (quo[QW-1]) begin
      sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SB-1){1'b1}}};
    end
    out_d = ctrl_i.load_out ? sat : out_q;
  end

  always_ff @(posedge clk_i) begin
    dry_prod_q <= dry_prod_d;
    wet_prod_q <= wet_prod_d;
    out_q      <= out_d;
  end

  assign out_o = out_q;

endmodule

### hdl/stereo_crossfeed_delay.sv
// stereo_crossfeed_delay: crossfeed with per-channel delay line of shifting cells
// one beat per cycle sustained while out_o.ready is high, set by the cell row
// shifting once per accepted beat and a 3-stage pipeline (tap group select,
// products, round and saturate)
// reset clears every history cell, the pipeline valids and the registers to
// delay 0, dry gain 1.0, wet gain 0, no swap
module stereo_crossfeed_delay #(
  parameter int unsigned HISTORY_DEPTH = 128,
  parameter int unsigned SAMPLE_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  scd_in_if.sink                          in_i,
  scd_out_if.source                       out_o
);
  import scd_pkg::*;

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned MAX_TAP = 2 ** DELAY_W;
  localparam int unsigned TAPS    = (HISTORY_DEPTH < MAX_TAP) ? HISTORY_DEPTH : MAX_TAP;
  localparam int unsigned NCELL   = TAPS - 1;
  localparam int unsigned NGRP    = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned HI_W    = DELAY_W - GROUP_W;
  localparam logic [DELAY_W-1:0] MAX_D = DELAY_W'(TAPS - 1);

  // configuration
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [GAIN_W-1:0]  dry_q, dry_d;
  logic [GAIN_W-1:0]  wet_q, wet_d;
  logic               swap_q, swap_d;

  always_comb begin
    delay_d = delay_q;
    dry_d   = dry_q;
    wet_d   = wet_q;
    swap_d  = swap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY: delay_d = cfg_data_i[DELAY_W-1:0];
        CFG_DRY:   dry_d   = cfg_data_i[GAIN_W-1:0];
        CFG_WET:   wet_d   = cfg_data_i[GAIN_W-1:0];
        CFG_SWAP:  swap_d  = cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
      dry_q   <= DRY_RST;
      wet_q   <= WET_RST;
      swap_q  <= 1'b0;
    end else begin
      delay_q <= delay_d;
      dry_q   <= dry_d;
      wet_q   <= wet_d;
      swap_q  <= swap_d;
    end
  end

  // pipeline flow control: a stage moves when the one after it is empty or moving
  logic va_q, vb_q, vc_q;
  logic adv_a, adv_b, adv_c;
  logic accept;

  assign adv_c  = !vc_q || out_o.ready;
  assign adv_b  = !vb_q || adv_c;
  assign adv_a  = !va_q || adv_b;
  assign accept = in_i.valid && adv_a;
  assign in_i.ready = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= in_i.valid;
      if (adv_b) vb_q <= va_q;
      if (adv_c) vc_q <= vb_q;
    end
  end

  // near samples after optional swap
  logic signed [SB-1:0] near_l, near_r;
  assign near_l = swap_q ? in_i.right_in : in_i.left_in;
  assign near_r = swap_q ? in_i.left_in  : in_i.right_in;

  // tap k holds the pair from k beats ago; tap 0 is the incoming pair
  logic signed [SB-1:0] tap_l [NGRP*GROUP_SIZE];
  logic signed [SB-1:0] tap_r [NGRP*GROUP_SIZE];

  assign tap_l[0] = near_l;
  assign tap_r[0] = near_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    scd_cell #(
      .SB (SB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .left_i  (tap_l[k]),
      .right_i (tap_r[k]),
      .left_o  (tap_l[k+1]),
      .right_o (tap_r[k+1])
    );
  end

  for (genvar k = TAPS; k < NGRP * GROUP_SIZE; k++) begin : g_pad
    assign tap_l[k] = '0;
    assign tap_r[k] = '0;
  end

  // stage a: pick one tap inside each group of sixteen
  logic [DELAY_W-1:0]   dsat;
  logic [GROUP_W-1:0]   dlo;
  logic signed [SB-1:0] cand_l_d [NGRP];
  logic signed [SB-1:0] cand_r_d [NGRP];
  logic signed [SB-1:0] cand_l_q [NGRP];
  logic signed [SB-1:0] cand_r_q [NGRP];
  logic [HI_W-1:0]      dhi_q;
  logic signed [SB-1:0] near_l_q, near_r_q;

  always_comb begin
    dsat = (delay_q > MAX_D) ? MAX_D : delay_q;
    dlo  = dsat[GROUP_W-1:0];
    for (int g = 0; g < NGRP; g++) begin
      cand_l_d[g] = '0;
      cand_r_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (dlo == GROUP_W'(j)) begin
          cand_l_d[g] = tap_l[g*GROUP_SIZE + j];
          cand_r_d[g] = tap_r[g*GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      for (int g = 0; g < NGRP; g++) begin
        cand_l_q[g] <= cand_l_d[g];
        cand_r_q[g] <= cand_r_d[g];
      end
      dhi_q    <= dsat[DELAY_W-1:GROUP_W];
      near_l_q <= near_l;
      near_r_q <= near_r;
    end
  end

  // stage b: pick the group, products are registered inside the mixers
  logic signed [SB-1:0] far_l, far_r;

  always_comb begin
    far_l = '0;
    far_r = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (dhi_q == HI_W'(g)) begin
        far_l = cand_l_q[g];
        far_r = cand_r_q[g];
      end
    end
  end

  scd_mix_ctrl_t mix_ctrl;
  assign mix_ctrl.load_prod = adv_b;
  assign mix_ctrl.load_out  = adv_c;

  // each side mixes its own sample with the opposite delayed sample
  scd_mix #(
    .SB (SB)
  ) u_mix_left (
    .clk_i  (clk_i),
    .ctrl_i (mix_ctrl),
    .near_i (near_l_q),
    .far_i  (far_r),
    .dry_i  (dry_q),
    .wet_i  (wet_q),
    .out_o  (out_o.left_out)
  );

  scd_mix #(
    .SB (SB)
  ) u_mix_right (
    .clk_i  (clk_i),
    .ctrl_i (mix_ctrl),
    .near_i (near_r_q),
    .far_i  (far_l),
    .dry_i  (dry_q),
    .wet_i  (wet_q),
    .out_o  (out_o.right_out)
  );

  assign out_o.valid = vc_q;

endmodule
